### design/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and codes for the shared dual stack
// Command and status encodings, plus the control and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam int WORD_W = 32;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              cap_in;
		logic              mem_we;
		logic              mem_re;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              set_res;
		logic [STAT_W-1:0] res_status;
		logic              res_rd;
		logic              load_out;
	} sds_ctl_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             out_free;
	} sds_sts_t;

endpackage

### design/shared_dual_stack.sv
// ----------------------------------------------------------------------------
// shared_dual_stack: two stacks sharing one word memory
// Stack 0 grows up from address 0, stack 1 grows down from DEPTH-1.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave channel is one transfer: s_tuser carries the
// command (push, pop, peek) and the side, s_tdata the word to push. Every
// request yields exactly one result transfer on the master channel, with the
// status in m_tuser and the popped or peeked word in m_tdata (zero for a
// push, a refused request or an unused command).
// A push is refused as full once both stacks together hold DEPTH words; a
// pop or peek on an empty side is refused as empty.
// Timing: a request is accepted in the idle state, executed against the
// memory in the execute state (one write, or one read into the registered
// read port), and its result is loaded into the output register in the
// load state. Requests are taken one at a time: a new request is accepted
// only once the last result has been loaded. The output register separates
// the two sides, so a new request is accepted while an earlier result
// waits. If m_tready stays low, the next request is held before its result
// load until the slot frees.
// Reset clears both stack counts and the output valid; memory contents are
// not cleared and need no clearing pass, since only written words are read.
// ----------------------------------------------------------------------------
module shared_dual_stack #(
	parameter int DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] push_value
	input  logic [2:0]  s_tuser,  // [1:0] cmd, [2] side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] read_value
	output logic [1:0]  m_tuser   // [1:0] status
);
	import sds_pkg::*;

	sds_ctl_t ctl;
	sds_sts_t sts;

	// The sequencer decides each request's outcome; the datapath holds state.
	sds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	sds_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_cmd     (s_tuser[1:0]),
		.in_side    (s_tuser[2]),
		.in_word    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_value  (m_tdata)
	);

	// A memory write is never issued against a full store.
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mem_we |-> !sts.full)
		else $error("memory write issued while store full");

	// One memory access per request: never write and read together.
	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.mem_we && ctl.mem_re))
		else $error("simultaneous memory write and read");

	// Requests are taken one at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// A refused request never returns data.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
		else $error("refused request returned nonzero data");

endmodule

### design/sds_ctrl.sv
// ----------------------------------------------------------------------------
// sds_ctrl: command sequencer for the shared dual stack
// Takes one request at a time, decides its outcome from the datapath status
// and steps it through execute and result load.
// ----------------------------------------------------------------------------
module sds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sds_pkg::sds_sts_t sts,
	output sds_pkg::sds_ctl_t ctl
);
	import sds_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.cap_in = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.set_res    = 1'b1;
				ctl.res_status = ST_OK;
				case (sts.cmd)
					CMD_PUSH: begin
						if (sts.full) begin
							ctl.res_status = ST_FULL;
						end else begin
							ctl.mem_we  = 1'b1;
							ctl.cnt_inc = 1'b1;
						end
					end
					CMD_POP, CMD_PEEK: begin
						if (sts.empty) begin
							ctl.res_status = ST_EMPTY;
						end else begin
							ctl.mem_re  = 1'b1;
							ctl.res_rd  = 1'b1;
							ctl.cnt_dec = (sts.cmd == CMD_POP);
						end
					end
					default: begin
						// Unused command: no state change, plain success.
						ctl.res_status = ST_OK;
					end
				endcase
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/sds_dpath.sv
// ----------------------------------------------------------------------------
// sds_dpath: storage and pointers of the shared dual stack
// Holds the request, both stack counts, the shared word memory with a
// registered read port, and the result output register.
// ----------------------------------------------------------------------------
module sds_dpath #(
	parameter int DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sds_pkg::sds_ctl_t             ctl,
	output sds_pkg::sds_sts_t             sts,
	input  logic [sds_pkg::CMD_W-1:0]     in_cmd,
	input  logic                          in_side,
	input  logic [sds_pkg::WORD_W-1:0]    in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sds_pkg::STAT_W-1:0]    out_status,
	output logic [sds_pkg::WORD_W-1:0]    out_value
);
	import sds_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

	logic [CMD_W-1:0]  cmd_q;
	logic              side_q;
	logic [WORD_W-1:0] word_q;
	logic [CW-1:0]     lower_q;
	logic [CW-1:0]     upper_q;
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [STAT_W-1:0] res_status_q;
	logic              res_rd_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [WORD_W-1:0] out_value_q;

	logic [CW:0]   used;
	logic [CW-1:0] addr_full;
	logic [AW-1:0] addr;

	assign used = {1'b0, lower_q} + {1'b0, upper_q};

	// Push goes to the next free word of the side; pop and peek read its top.
	always_comb begin
		if (ctl.mem_we) begin
			addr_full = side_q ? (DEPTH_C - upper_q - CW'(1)) : lower_q;
		end else begin
			addr_full = side_q ? (DEPTH_C - upper_q) : (lower_q - CW'(1));
		end
	end
	assign addr = addr_full[AW-1:0];

	assign sts.cmd      = cmd_q;
	assign sts.full     = (used >= DEPTH_S);
	assign sts.empty    = side_q ? (upper_q == '0) : (lower_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			cmd_q  <= in_cmd;
			side_q <= in_side;
			word_q <= in_word;
		end
		if (ctl.set_res) begin
			res_status_q <= ctl.res_status;
			res_rd_q     <= ctl.res_rd;
		end
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_rd_q ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			mem[addr] <= word_q;
		end
		if (ctl.mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q     <= '0;
			upper_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.cnt_inc) begin
				if (side_q) begin
					upper_q <= upper_q + CW'(1);
				end else begin
					lower_q <= lower_q + CW'(1);
				end
			end else if (ctl.cnt_dec) begin
				if (side_q) begin
					upper_q <= upper_q - CW'(1);
				end else begin
					lower_q <= lower_q - CW'(1);
				end
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;

endmodule

### dv/shared_dual_stack_tb.sv
// ----------------------------------------------------------------------------
// shared_dual_stack_tb: self-checking bench for the shared dual stack
// Drives push, pop, peek and unused commands on both sides. A predictor
// keeps its own copy of both stack counts and of the word memory, and works
// out the status and word of each result. The sender runs in bursts with
// gaps. The receiver stalls on a changing pattern and once holds off long
// enough for the block to stall its input.
// ----------------------------------------------------------------------------
module shared_dual_stack_tb;
	import sds_pkg::*;

	localparam int DEPTH = 128;
	localparam int CLK_HALF = 6;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] read_value;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	// Predictor state: word counts of both stacks and the shared memory.
	logic [7:0]        lower_cnt;
	logic [7:0]        upper_cnt;
	logic [WORD_W-1:0] stack_mem [0:DEPTH-1];

	reply_t pending_replies [$];
	int     mismatch_count;
	int     burst_left;
	int     hold_request;

	shared_dual_stack #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Applies one request to the predicted stacks and returns its result.
	function automatic reply_t apply_stack_op(logic [CMD_W-1:0] cmd, logic side,
			logic [WORD_W-1:0] word);
		reply_t r;
		r.status = ST_OK;
		r.read_value = '0;
		case (cmd)
			CMD_PUSH: begin
				if (int'(lower_cnt) + int'(upper_cnt) >= DEPTH) begin
					r.status = ST_FULL;
				end else if (!side) begin
					stack_mem[lower_cnt] = word;
					lower_cnt++;
				end else begin
					upper_cnt++;
					stack_mem[DEPTH - int'(upper_cnt)] = word;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if ((side ? upper_cnt : lower_cnt) == 0) begin
					r.status = ST_EMPTY;
				end else if (!side) begin
					r.read_value = stack_mem[int'(lower_cnt) - 1];
					if (cmd == CMD_POP) lower_cnt--;
				end else begin
					r.read_value = stack_mem[DEPTH - int'(upper_cnt)];
					if (cmd == CMD_POP) upper_cnt--;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random words in half the picks; the signed extremes, zero and all ones in the rest.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Offers one request and returns at the edge where it was accepted. Between
	// bursts the valid is dropped for a random number of cycles; a gap of zero
	// keeps bursts back to back.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic side,
			input logic [WORD_W-1:0] word);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= {side, cmd};
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(apply_stack_op(cmd, side, word));
		burst_left--;
	endtask

	// Empty sides, the unused command, extreme words, and a push followed at
	// once by a peek and a pop of the same word.
	task automatic test_directed();
		send_request(CMD_POP, 1'b0, 32'h1234_5678);
		send_request(CMD_PEEK, 1'b0, 32'h0);
		send_request(CMD_POP, 1'b1, 32'hFFFF_FFFF);
		send_request(CMD_PEEK, 1'b1, 32'h0);
		send_request(CMD_UNUSED, 1'b0, 32'h0);
		send_request(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF);
		send_request(CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
		send_request(CMD_PUSH, 1'b0, 32'h8000_0000);
		send_request(CMD_PUSH, 1'b1, 32'hFFFF_FFFF);
		send_request(CMD_PUSH, 1'b1, 32'h0000_0000);
		send_request(CMD_PEEK, 1'b0, 32'h0);
		send_request(CMD_PEEK, 1'b1, 32'h0);
		send_request(CMD_UNUSED, 1'b0, 32'h5555_AAAA);
		send_request(CMD_POP, 1'b0, 32'h0);
		send_request(CMD_POP, 1'b0, 32'h0);
		send_request(CMD_POP, 1'b0, 32'h0);
		send_request(CMD_POP, 1'b1, 32'h0);
		send_request(CMD_PEEK, 1'b1, 32'h0);
		send_request(CMD_POP, 1'b1, 32'h0);
		send_request(CMD_POP, 1'b1, 32'h0);
		send_request(CMD_PUSH, 1'b1, 32'hA5A5_5A5A);
		send_request(CMD_PEEK, 1'b1, 32'h0);
		send_request(CMD_POP, 1'b1, 32'h0);
	endtask

	// Fills the whole memory with the lower stack taking about lower_share
	// words, pushes into the full memory from both sides, then drains both
	// stacks and asks both empty sides once more.
	task automatic test_store_full(input int lower_share);
		logic side;
		while (int'(lower_cnt) + int'(upper_cnt) < DEPTH) begin
			if (int'(lower_cnt) >= lower_share)
				side = 1'b1;
			else if (int'(upper_cnt) >= DEPTH - lower_share)
				side = 1'b0;
			else
				side = 1'($urandom_range(0, 1));
			send_request(CMD_PUSH, side, pick_word());
		end
		send_request(CMD_PUSH, 1'b0, pick_word());
		send_request(CMD_PUSH, 1'b1, pick_word());
		send_request(CMD_PEEK, 1'b0, 32'h0);
		send_request(CMD_PEEK, 1'b1, 32'h0);
		send_request(CMD_UNUSED, 1'($urandom_range(0, 1)), pick_word());
		while (lower_cnt != 0 || upper_cnt != 0) begin
			if (lower_cnt == 0)
				side = 1'b1;
			else if (upper_cnt == 0)
				side = 1'b0;
			else
				side = 1'($urandom_range(0, 1));
			send_request(($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_POP, side,
				pick_word());
		end
		send_request(CMD_POP, 1'b0, pick_word());
		send_request(CMD_PEEK, 1'b1, pick_word());
	endtask

	// The receiver holds off for a long stretch while requests keep coming,
	// so the result path backs up and the block stops taking requests.
	task automatic test_result_backpressure();
		hold_request = 400;
		for (int k = 0; k < 16; k++)
			send_request(CMD_PUSH, 1'($urandom_range(0, 1)), pick_word());
		for (int k = 0; k < 16; k++)
			send_request(($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_POP,
				1'($urandom_range(0, 1)), pick_word());
	endtask

	// Random phases that lean toward filling, draining or neither, so that
	// the run keeps reaching both a full memory and empty sides.
	task automatic test_random_phases(input int n_items);
		int done;
		int phase_len;
		int push_pct;
		int pop_pct;
		int side_pct;
		int roll;
		logic [CMD_W-1:0] cmd;
		done = 0;
		while (done < n_items) begin
			phase_len = $urandom_range(40, 250);
			case ($urandom_range(0, 2))
				0: begin
					push_pct = 75;
					pop_pct  = 15;
				end
				1: begin
					push_pct = 25;
					pop_pct  = 55;
				end
				default: begin
					push_pct = 45;
					pop_pct  = 35;
				end
			endcase
			side_pct = $urandom_range(10, 90);
			for (int k = 0; k < phase_len && done < n_items; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					cmd = CMD_UNUSED;
				else if (roll < push_pct)
					cmd = CMD_PUSH;
				else if (roll < push_pct + pop_pct)
					cmd = CMD_POP;
				else
					cmd = CMD_PEEK;
				send_request(cmd, $urandom_range(0, 99) < side_pct, pick_word());
				done++;
			end
		end
	endtask

	// Receiver: switches between always ready, coin flips, rare readiness and
	// a short periodic stall; a hold-off request overrides all of them.
	initial begin : result_sink
		int hold_cnt;
		int mode;
		int mode_left;
		hold_cnt  = 0;
		mode      = 0;
		mode_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_cnt     = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(30, 300);
			end
			mode_left--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((mode_left % 8) != 0);
				endcase
			end
		end
	end

	// Every result transfer is matched against the oldest predicted result.
	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: result with none predicted: status %0d read_value %h",
					$time, m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_tuser);
					mismatch_count++;
				end
				if (m_tdata !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h",
						$time, want.read_value, m_tdata);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(2 * CLK_HALF * 400000);
		$display("shared_dual_stack_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		lower_cnt      = '0;
		upper_cnt      = '0;
		mismatch_count = 0;
		burst_left     = 0;
		hold_request   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_store_full(DEPTH);
		test_store_full(0);
		test_store_full($urandom_range(1, DEPTH - 1));
		test_result_backpressure();
		test_random_phases(880);

		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("shared_dual_stack_tb: PASS");
		else
			$display("shared_dual_stack_tb: FAIL");
		$finish;
	end

endmodule

### files.f
design/sds_pkg.sv
design/sds_ctrl.sv
design/sds_dpath.sv
design/shared_dual_stack.sv
dv/shared_dual_stack_tb.sv
